[rtl/sbcs_pkg.sv]
// ----------------------------------------------------------------------------
// sbcs_pkg
// Shared constants, command codes, store request type and byte helpers for
// the slot bitmap search block.
// ----------------------------------------------------------------------------
package sbcs_pkg;

	localparam int MAX_BYTES = 32;
	localparam int ADDR_W    = $clog2(MAX_BYTES);
	localparam int LEN_W     = 6;

	localparam logic [3:0] CMD_SET        = 4'd0;
	localparam logic [3:0] CMD_GET        = 4'd1;
	localparam logic [3:0] CMD_FILL       = 4'd2;
	localparam logic [3:0] CMD_OR_BYTE    = 4'd3;
	localparam logic [3:0] CMD_WRITE_BYTE = 4'd4;
	localparam logic [3:0] CMD_NEXT_SET   = 4'd5;
	localparam logic [3:0] CMD_NEXT_CLEAR = 4'd6;
	localparam logic [3:0] CMD_RAND_CLEAR = 4'd7;
	localparam logic [3:0] CMD_COUNT      = 4'd8;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [ADDR_W-1:0]    wr_addr;
		logic [7:0]           wr_data;
		logic                 clr;
		logic [MAX_BYTES-1:0] keep;
	} store_req_t;

	// index of the lowest set bit, 0 when none
	function automatic logic [2:0] lowest_one(input logic [7:0] m);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [3:0] popcount8(input logic [7:0] m);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(m[i]);
		end
		return c;
	endfunction

endpackage

[rtl/sbcs_store.sv]
// ----------------------------------------------------------------------------
// sbcs_store
// Bitmap byte memory: one write and one registered read per cycle, with a
// per-byte valid flag so unwritten or trimmed bytes read as zero.
// ----------------------------------------------------------------------------
module sbcs_store (
	input  logic                clk,
	input  logic                arst_n,
	input  sbcs_pkg::store_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0]                     mem [sbcs_pkg::MAX_BYTES];
	logic [sbcs_pkg::MAX_BYTES-1:0] vld_q;
	logic [7:0]                     rd_mem_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_mem_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			// length change drops bytes past the new end
			if (req.clr) begin
				vld_q <= vld_q & req.keep;
			end
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_mem_q : 8'h00;

endmodule

[rtl/sbcs_mod.sv]
// ----------------------------------------------------------------------------
// sbcs_mod
// Restoring remainder unit, one dividend bit per cycle; gives the start
// byte of the random clear-bit search.
// ----------------------------------------------------------------------------
module sbcs_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] dividend,
	input  logic [5:0]  divisor,
	output logic        done,
	output logic [5:0]  rem
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [12:0] dvd_q;
	logic [5:0]  div_q;
	logic [5:0]  rem_q;
	logic [5:0]  rem_sh;

	// remainder stays below the divisor, so it fits in five bits before the shift
	assign rem_sh = {rem_q[4:0], dvd_q[12]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd12) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[11:0], 1'b0};
			rem_q <= (rem_sh >= div_q) ? (rem_sh - div_q) : rem_sh;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[rtl/slot_bitmap_circular_search.sv]
// ----------------------------------------------------------------------------
// slot_bitmap_circular_search
// Slot allocation bitmap with single-bit access, byte merge, fill, circular
// find-first searches and population count.
// ----------------------------------------------------------------------------
// One command beat is worked at a time; input stall is high from acceptance
// until the result is placed in the output register, which may still wait
// while the next command is taken. The bitmap is a 32-byte memory with one
// registered read port, scanned one byte per cycle. Set, get and or-byte read
// the addressed byte, set and or-byte write back the update; write-byte writes on
// acceptance and rejected commands go straight to output. Fill writes each
// byte in turn; next-set, next-clear and count scan the bytes; random-clear
// first finds its start byte with the serial remainder. Reset clears the
// bitmap at once through per-byte valid flags; there is no clearing pass.
module slot_bitmap_circular_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [5:0]  length_bytes,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [7:0]  position,
	input  logic        bit_value,
	input  logic [4:0]  byte_index,
	input  logic [7:0]  byte_data,
	input  logic [15:0] random_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [7:0]  slot,
	output logic        bit_out,
	output logic [8:0]  set_count,
	output logic        in_range
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RMW  = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam int AW = sbcs_pkg::ADDR_W;
	localparam int LW = sbcs_pkg::LEN_W;

	logic [2:0]    state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] n_bytes;
	logic [AW-1:0] n_last;
	logic [LW-1:0] n_new;

	logic [3:0]    cmd_q;
	logic [7:0]    pos_q;
	logic          bv_q;
	logic [7:0]    bdat_q;
	logic [AW-1:0] rmw_addr_q;

	logic [AW-1:0] addr_q;
	logic [LW-1:0] k_q;
	logic [LW-1:0] last_k_q;
	logic [2:0]    off_q;
	logic          want_q;
	logic          count_q;
	logic [8:0]    acc_q;
	logic [AW-1:0] fill_q;

	logic          rv_s1;
	logic [LW-1:0] k_s1;
	logic [AW-1:0] addr_s1;

	logic          res_found_q;
	logic [7:0]    res_slot_q;
	logic          res_bit_q;
	logic [8:0]    res_cnt_q;
	logic          res_inr_q;

	logic          out_valid_q;
	logic          found_q;
	logic [7:0]    slot_q;
	logic          bit_out_q;
	logic [8:0]    set_count_q;
	logic          in_range_q;

	logic          accept;
	logic          len_ok;
	logic          pos_ok;
	logic          byte_ok;
	logic          scan_rd;
	logic          mod_start;
	logic          mod_done;
	logic [5:0]    mod_rem;
	logic [7:0]    rdata;
	logic [7:0]    bit_mask;
	logic [7:0]    rmw_byte;
	logic [7:0]    scan_mask;
	logic [7:0]    scan_hit;
	logic [8:0]    acc_next;
	logic          load_out;

	sbcs_pkg::store_req_t store_req;

	// effective length, limited to the store depth
	assign n_bytes = (len_q > LW'(sbcs_pkg::MAX_BYTES)) ? LW'(sbcs_pkg::MAX_BYTES) : len_q;
	assign n_last  = AW'(n_bytes - LW'(1));
	assign n_new   = (length_bytes > LW'(sbcs_pkg::MAX_BYTES)) ?
		LW'(sbcs_pkg::MAX_BYTES) : length_bytes;

	assign accept  = (state_q == ST_IDLE) && in_valid;
	assign len_ok  = (n_bytes != '0);
	assign pos_ok  = len_ok && ({1'b0, position[7:3]} < n_bytes);
	assign byte_ok = len_ok && ({1'b0, byte_index} < n_bytes);
	assign scan_rd = (state_q == ST_SCAN) && (k_q <= last_k_q);
	assign mod_start = accept && (command == sbcs_pkg::CMD_RAND_CLEAR) && len_ok;

	assign bit_mask = 8'h01 << pos_q[2:0];
	assign rmw_byte = (cmd_q == sbcs_pkg::CMD_OR_BYTE) ? (rdata | bdat_q) :
		(bv_q ? (rdata | bit_mask) : (rdata & ~bit_mask));

	// first byte of a circular search skips bits below the start, the wrap byte keeps only those
	always_comb begin
		scan_mask = 8'hFF;
		if (k_s1 == '0) begin
			scan_mask = 8'hFF << off_q;
		end else if (k_s1 == n_bytes) begin
			scan_mask = (8'h01 << off_q) - 8'h01;
		end
	end

	assign scan_hit = (want_q ? rdata : ~rdata) & scan_mask;
	assign acc_next = acc_q + 9'(sbcs_pkg::popcount8(rdata));
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		store_req = '0;
		if (accept && (command inside {sbcs_pkg::CMD_SET, sbcs_pkg::CMD_GET,
				sbcs_pkg::CMD_OR_BYTE})) begin
			store_req.rd_en   = 1'b1;
			store_req.rd_addr = (command == sbcs_pkg::CMD_OR_BYTE) ? byte_index : position[7:3];
		end else if (scan_rd) begin
			store_req.rd_en   = 1'b1;
			store_req.rd_addr = addr_q;
		end
		if (accept && (command == sbcs_pkg::CMD_WRITE_BYTE) && byte_ok) begin
			store_req.wr_en   = 1'b1;
			store_req.wr_addr = byte_index;
			store_req.wr_data = byte_data;
		end else if ((state_q == ST_RMW) && (cmd_q != sbcs_pkg::CMD_GET)) begin
			store_req.wr_en   = 1'b1;
			store_req.wr_addr = rmw_addr_q;
			store_req.wr_data = rmw_byte;
		end else if (state_q == ST_FILL) begin
			store_req.wr_en   = 1'b1;
			store_req.wr_addr = fill_q;
			store_req.wr_data = bv_q ? 8'hFF : 8'h00;
		end
		store_req.clr = cfg_write;
		for (int b = 0; b < sbcs_pkg::MAX_BYTES; b++) begin
			store_req.keep[b] = (LW'(b) < n_new);
		end
	end

	sbcs_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (rdata)
	);

	sbcs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (random_number[15:3]),
		.divisor  (n_bytes),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				len_q <= length_bytes;
			end
			rv_s1 <= scan_rd;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_OUT;
						case (command)
							sbcs_pkg::CMD_SET, sbcs_pkg::CMD_GET: begin
								if (pos_ok) state_q <= ST_RMW;
							end
							sbcs_pkg::CMD_OR_BYTE: begin
								if (byte_ok) state_q <= ST_RMW;
							end
							sbcs_pkg::CMD_FILL: begin
								if (len_ok) state_q <= ST_FILL;
							end
							sbcs_pkg::CMD_NEXT_SET: begin
								if (pos_ok) state_q <= ST_SCAN;
							end
							sbcs_pkg::CMD_NEXT_CLEAR, sbcs_pkg::CMD_COUNT: begin
								if (len_ok) state_q <= ST_SCAN;
							end
							sbcs_pkg::CMD_RAND_CLEAR: begin
								if (len_ok) state_q <= ST_MOD;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RMW: begin
					state_q <= ST_OUT;
				end
				ST_FILL: begin
					if (fill_q == n_last) state_q <= ST_OUT;
				end
				ST_MOD: begin
					if (mod_done) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rv_s1) begin
						if (!count_q && (scan_hit != 8'h00)) begin
							state_q <= ST_OUT;
						end else if (k_s1 == last_k_q) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		addr_s1 <= addr_q;
		if (accept) begin
			cmd_q       <= command;
			pos_q       <= position;
			bv_q        <= bit_value;
			bdat_q      <= byte_data;
			rmw_addr_q  <= (command == sbcs_pkg::CMD_OR_BYTE) ? byte_index : position[7:3];
			fill_q      <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			count_q     <= (command == sbcs_pkg::CMD_COUNT);
			want_q      <= (command == sbcs_pkg::CMD_NEXT_SET);
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			res_bit_q   <= 1'b0;
			res_cnt_q   <= '0;
			res_inr_q   <= 1'b0;
			addr_q      <= '0;
			off_q       <= '0;
			last_k_q    <= n_bytes - LW'(1);
			case (command)
				sbcs_pkg::CMD_SET, sbcs_pkg::CMD_GET: begin
					res_inr_q <= pos_ok;
				end
				sbcs_pkg::CMD_OR_BYTE, sbcs_pkg::CMD_WRITE_BYTE: begin
					res_inr_q <= byte_ok;
				end
				sbcs_pkg::CMD_FILL, sbcs_pkg::CMD_NEXT_CLEAR, sbcs_pkg::CMD_COUNT: begin
					res_inr_q <= len_ok;
				end
				sbcs_pkg::CMD_NEXT_SET: begin
					res_inr_q <= pos_ok;
					addr_q    <= position[7:3];
					off_q     <= position[2:0];
					if (position[2:0] != 3'd0) last_k_q <= n_bytes;
				end
				sbcs_pkg::CMD_RAND_CLEAR: begin
					res_inr_q <= len_ok;
					off_q     <= random_number[2:0];
					if (random_number[2:0] != 3'd0) last_k_q <= n_bytes;
				end
				default: begin
					res_inr_q <= 1'b0;
				end
			endcase
		end
		if (state_q == ST_RMW) begin
			res_found_q <= (cmd_q != sbcs_pkg::CMD_OR_BYTE);
			res_bit_q   <= (cmd_q == sbcs_pkg::CMD_GET) && rdata[pos_q[2:0]];
		end
		if (state_q == ST_FILL) begin
			fill_q <= fill_q + AW'(1);
		end
		if ((state_q == ST_MOD) && mod_done) begin
			addr_q <= mod_rem[AW-1:0];
		end
		if (scan_rd) begin
			k_q    <= k_q + LW'(1);
			addr_q <= (addr_q == n_last) ? '0 : addr_q + AW'(1);
		end
		if ((state_q == ST_SCAN) && rv_s1) begin
			if (count_q) begin
				acc_q     <= acc_next;
				res_cnt_q <= acc_next;
			end else if (scan_hit != 8'h00) begin
				res_found_q <= 1'b1;
				res_slot_q  <= {addr_s1, sbcs_pkg::lowest_one(scan_hit)};
			end
		end
		if (load_out) begin
			found_q     <= res_found_q;
			slot_q      <= res_slot_q;
			bit_out_q   <= res_bit_q;
			set_count_q <= res_cnt_q;
			in_range_q  <= res_inr_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign slot      = slot_q;
	assign bit_out   = bit_out_q;
	assign set_count = set_count_q;
	assign in_range  = in_range_q;

`ifndef ASSERT_OFF
	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("remainder finished outside its wait state");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!found_q || in_range_q))
		else $error("found reported for an out-of-range beat");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && rv_s1) |-> (k_s1 <= last_k_q))
		else $error("scan evaluated a byte past its last step");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.wr_en |-> (state_q != ST_SCAN))
		else $error("bitmap written during a search");
`endif

endmodule
